// ===== rtl/u2a_pkg.sv =====
// ----------------------------------------------------------------------------
// u2a_pkg
// Shared types, constants and the substitution table of the UTF-8 to ASCII
// transliterator.
// ----------------------------------------------------------------------------
package u2a_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CharW   = 7;
  localparam int unsigned LenW    = 16;
  localparam int unsigned AccW    = 21;
  localparam int unsigned PendW   = 2;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  localparam logic [LenW-1:0] MaxLenReset = 16'd256;

  // code points with a two-letter substitute
  localparam logic [AccW-1:0] CpAeLower = 21'h0000E4;
  localparam logic [AccW-1:0] CpOeLower = 21'h0000F6;
  localparam logic [AccW-1:0] CpUeLower = 21'h0000FC;
  localparam logic [AccW-1:0] CpAeUpper = 21'h0000C4;
  localparam logic [AccW-1:0] CpOeUpper = 21'h0000D6;
  localparam logic [AccW-1:0] CpUeUpper = 21'h0000DC;
  localparam logic [AccW-1:0] CpSharpS  = 21'h0000DF;

  // one queue entry: up to two characters, or the terminator
  typedef struct packed {
    logic [CharW-1:0] char0;
    logic [CharW-1:0] char1;
    logic             two;
    logic             last;
  } op_t;

  typedef struct packed {
    logic             hit;
    logic [CharW-1:0] first;
    logic [CharW-1:0] second;
  } sub_t;

  function automatic sub_t lookup_sub(input logic [AccW-1:0] cp);
    sub_t s;
    s.hit    = 1'b1;
    s.first  = 7'h00;
    s.second = 7'h65; // 'e'
    unique case (cp)
      CpAeLower: s.first = 7'h61; // 'a'
      CpOeLower: s.first = 7'h6F; // 'o'
      CpUeLower: s.first = 7'h75; // 'u'
      CpAeUpper: s.first = 7'h41; // 'A'
      CpOeUpper: s.first = 7'h4F; // 'O'
      CpUeUpper: s.first = 7'h55; // 'U'
      CpSharpS: begin
        s.first  = 7'h73; // 's'
        s.second = 7'h73;
      end
      default: begin
        s.hit    = 1'b0;
        s.second = 7'h00;
      end
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/u2a_front.sv =====
// ----------------------------------------------------------------------------
// u2a_front
// Accepts bytes, runs the UTF-8 decoder state and the output character
// count, and turns each byte into at most one queue entry.
// ----------------------------------------------------------------------------
module u2a_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [u2a_pkg::LenW-1:0]    cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [u2a_pkg::ByteW-1:0]   in_byte_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output u2a_pkg::op_t                q_op_o
);

  logic [u2a_pkg::PendW-1:0] pend_q, pend_d;
  logic [u2a_pkg::AccW-1:0]  acc_q, acc_d, acc_n;
  logic [u2a_pkg::LenW-1:0]  cw_q, cw_d;
  logic [u2a_pkg::LenW-1:0]  maxlen_q;
  logic                      room1, room2, is_cont, push, fire;
  u2a_pkg::sub_t             sub;
  u2a_pkg::op_t              op;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && in_ready_o;
  assign q_push_o   = fire && push;
  assign q_op_o     = op;

  assign room1   = ({1'b0, cw_q} + 17'd1) < {1'b0, maxlen_q};
  assign room2   = ({1'b0, cw_q} + 17'd2) < {1'b0, maxlen_q};
  assign is_cont = (in_byte_i[7:6] == 2'b10);
  assign acc_n   = {acc_q[u2a_pkg::AccW-7:0], in_byte_i[5:0]};
  assign sub     = u2a_pkg::lookup_sub(acc_n);

  always_comb begin
    pend_d   = pend_q;
    acc_d    = acc_q;
    cw_d     = cw_q;
    push     = 1'b0;
    op.char0 = '0;
    op.char1 = '0;
    op.two   = 1'b0;
    op.last  = 1'b0;
    if (in_byte_i == '0) begin
      push    = 1'b1;
      op.last = 1'b1;
      pend_d  = '0;
      acc_d   = '0;
      cw_d    = '0;
    end else if (room1) begin
      if (pend_q != '0 && is_cont) begin
        pend_d = pend_q - 2'd1;
        acc_d  = acc_n;
        if (pend_q == 2'd1) begin
          acc_d = '0;
          if (sub.hit) begin
            push     = 1'b1;
            op.char0 = sub.first;
            op.char1 = sub.second;
            op.two   = room2;
            cw_d     = room2 ? cw_q + 16'd2 : cw_q + 16'd1;
          end
        end
      end else begin
        // a broken sequence is dropped and this byte starts over
        pend_d = '0;
        acc_d  = '0;
        if (!in_byte_i[7]) begin
          push     = 1'b1;
          op.char0 = in_byte_i[6:0];
          cw_d     = cw_q + 16'd1;
        end else if (in_byte_i[7:5] == 3'b110) begin
          acc_d  = {16'd0, in_byte_i[4:0]};
          pend_d = 2'd1;
        end else if (in_byte_i[7:4] == 4'b1110) begin
          acc_d  = {17'd0, in_byte_i[3:0]};
          pend_d = 2'd2;
        end else if (in_byte_i[7:3] == 5'b11110) begin
          acc_d  = {18'd0, in_byte_i[2:0]};
          pend_d = 2'd3;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      acc_q  <= '0;
      cw_q   <= '0;
    end else if (fire) begin
      pend_q <= pend_d;
      acc_q  <= acc_d;
      cw_q   <= cw_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxlen_q <= u2a_pkg::MaxLenReset;
    end else if (cfg_we_i) begin
      maxlen_q <= cfg_wdata_i;
    end
  end

endmodule

// ===== rtl/u2a_fifo.sv =====
// ----------------------------------------------------------------------------
// u2a_fifo
// Short queue of decoded entries between the front and the back end.
// ----------------------------------------------------------------------------
module u2a_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  u2a_pkg::op_t  push_op_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output u2a_pkg::op_t  head_o
);

  u2a_pkg::op_t              mem_q [u2a_pkg::QDepth];
  logic [u2a_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [u2a_pkg::QCntW-1:0] cnt_q;
  logic                      do_push, do_pop;

  assign full_o  = (cnt_q == u2a_pkg::QCntW'(u2a_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/u2a_back.sv =====
// ----------------------------------------------------------------------------
// u2a_back
// Drains queue entries into the output register, one character per
// transaction; a two-letter entry takes two transactions.
// ----------------------------------------------------------------------------
module u2a_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  input  u2a_pkg::op_t               q_head_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [u2a_pkg::CharW-1:0]  out_char_o,
  output logic                       last_o
);

  logic                      out_valid_q;
  logic [u2a_pkg::CharW-1:0] out_char_q;
  logic                      last_q;
  logic                      sel_q;
  logic                      load;

  assign load        = !out_valid_q || out_ready_i;
  // pop once the final character of the head entry is loaded
  assign q_pop_o     = load && !q_empty_i && (sel_q || !q_head_i.two);
  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else if (load) begin
      out_valid_q <= !q_empty_i;
      if (!q_empty_i) begin
        sel_q <= q_head_i.two && !sel_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !q_empty_i) begin
      out_char_q <= sel_q ? q_head_i.char1 : q_head_i.char0;
      last_q     <= q_head_i.last;
    end
  end

endmodule

// ===== rtl/utf8_to_ascii_transliterator.sv =====
// path: a byte's characters pass through the queue entry and then the output register
// throughput: one byte per cycle while the queue has room; a two-letter substitute
// holds the output for two transactions, and the 4-entry queue absorbs the extra one
// reset: decoder state and character count cleared, max_length set to 256,
// queue and output register emptied
// ----------------------------------------------------------------------------
// utf8_to_ascii_transliterator
// Decodes a UTF-8 byte stream and emits ASCII, with umlauts and sharp s
// replaced by two-letter substitutes and other non-ASCII characters dropped.
// ----------------------------------------------------------------------------
module utf8_to_ascii_transliterator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [u2a_pkg::LenW-1:0]   cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [u2a_pkg::ByteW-1:0]  in_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [u2a_pkg::CharW-1:0]  out_char_o,
  output logic                       last_o
);

  logic         q_push, q_pop, q_full, q_empty;
  u2a_pkg::op_t q_op, q_head;

  u2a_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_op_o      (q_op)
  );

  u2a_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (q_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .empty_o   (q_empty),
    .head_o    (q_head)
  );

  u2a_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_o      (last_o)
  );

endmodule

// ===== rtl/u2a_checker.sv =====
// ----------------------------------------------------------------------------
// u2a_checker
// Port-level assertions for the transliterator, bound to the top level.
// ----------------------------------------------------------------------------
module u2a_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [u2a_pkg::CharW-1:0]  out_char_o,
  input logic                       last_o
);

  // terminator carries character zero
  a_last_is_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> out_char_o == '0)
    else $error("terminator with nonzero character");

  // ordinary characters are never zero
  a_char_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> out_char_o != '0)
    else $error("zero character without last");

  // a full queue implies the output register is occupied
  a_full_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled while output is empty");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o) && $stable(last_o))
    else $error("stalled output transaction changed");

endmodule

bind utf8_to_ascii_transliterator u2a_checker u_u2a_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_char_o  (out_char_o),
  .last_o      (last_o)
);

// ===== tb/sv/utf8_to_ascii_transliterator_tb.sv =====
// ----------------------------------------------------------------------------
// utf8_to_ascii_transliterator_tb
// Feeds UTF-8 byte streams through the transliterator: a directed opening on
// ASCII, every substitute, overlong forms, broken and stray bytes, output
// limits and cut pairs, then random strings under changing max_length.
// Every transaction in is decoded in step by a scoreboard, and every character
// out is compared with the oldest character it predicts.
// ----------------------------------------------------------------------------
module utf8_to_ascii_transliterator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomBytes = 500;

  typedef struct packed {
    logic [u2a_pkg::CharW-1:0] ch;
    logic                      last;
  } ascii_out_t;

  class u2a_scoreboard;
    logic [u2a_pkg::LenW-1:0]  max_len;
    logic [u2a_pkg::PendW-1:0] pending;
    logic [u2a_pkg::AccW-1:0]  acc;
    logic [u2a_pkg::LenW-1:0]  written;
    ascii_out_t                expected_q[$];
    int unsigned               mismatches;

    function new();
      max_len    = u2a_pkg::MaxLenReset;
      pending    = '0;
      acc        = '0;
      written    = '0;
      mismatches = 0;
    endfunction

    function void set_max_len(logic [u2a_pkg::LenW-1:0] v);
      max_len = v;
    endfunction

    function bit has_room();
      return ({1'b0, written} + 17'd1) < {1'b0, max_len};
    endfunction

    function void put_char(logic [u2a_pkg::CharW-1:0] ch);
      if (!has_room()) return;
      expected_q.push_back('{ch: ch, last: 1'b0});
      written = written + 1'b1;
    endfunction

    function void put_substitute(logic [u2a_pkg::AccW-1:0] cp);
      logic [u2a_pkg::CharW-1:0] first;
      logic [u2a_pkg::CharW-1:0] second;
      second = 7'h65; // e
      case (cp)
        u2a_pkg::CpAeLower: first = 7'h61;
        u2a_pkg::CpOeLower: first = 7'h6F;
        u2a_pkg::CpUeLower: first = 7'h75;
        u2a_pkg::CpAeUpper: first = 7'h41;
        u2a_pkg::CpOeUpper: first = 7'h4F;
        u2a_pkg::CpUeUpper: first = 7'h55;
        u2a_pkg::CpSharpS: begin
          first  = 7'h73;
          second = 7'h73;
        end
        default: return;
      endcase
      put_char(first);
      put_char(second);
    endfunction

    // returns 0 when the byte is ignored because the output is full
    function bit note_byte(logic [u2a_pkg::ByteW-1:0] b);
      if (b == 8'h00) begin
        expected_q.push_back('{ch: 7'h00, last: 1'b1});
        pending = '0;
        acc     = '0;
        written = '0;
        return 1'b1;
      end
      if (!has_room()) return 1'b0;
      if (pending != 0) begin
        if (b[7:6] == 2'b10) begin
          acc     = {acc[u2a_pkg::AccW-7:0], b[5:0]};
          pending = pending - 1'b1;
          if (pending == 0) begin
            put_substitute(acc);
            acc = '0;
          end
          return 1'b1;
        end
        // broken sequence: drop it, then decode this byte as new input
        pending = '0;
        acc     = '0;
      end
      if (!b[7]) begin
        put_char(b[6:0]);
      end else if (b[7:5] == 3'b110) begin
        acc     = 21'(b[4:0]);
        pending = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        acc     = 21'(b[3:0]);
        pending = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        acc     = 21'(b[2:0]);
        pending = 2'd3;
      end
      return 1'b1;
    endfunction

    function void note_error(string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR: %s", msg);
    endfunction

    function void check_char(logic [u2a_pkg::CharW-1:0] ch, logic lst);
      ascii_out_t e;
      if (expected_q.size() == 0) begin
        note_error($sformatf("unexpected out_char %h last %b", ch, lst));
        return;
      end
      e = expected_q.pop_front();
      if (e.ch !== ch || e.last !== lst)
        note_error($sformatf("out_char exp %h got %h, last exp %b got %b",
                             e.ch, ch, e.last, lst));
    endfunction
  endclass

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        cfg_we_i    = 1'b0;
  logic [u2a_pkg::LenW-1:0]    cfg_wdata_i = '0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic [u2a_pkg::ByteW-1:0]   in_byte_i   = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [u2a_pkg::CharW-1:0]   out_char_o;
  logic                        last_o;

  u2a_scoreboard               sb = new();
  logic [u2a_pkg::ByteW-1:0]   stim_q[$];
  logic [u2a_pkg::AccW-1:0]    sub_cps[7] = '{u2a_pkg::CpAeLower, u2a_pkg::CpOeLower,
                                              u2a_pkg::CpUeLower, u2a_pkg::CpAeUpper,
                                              u2a_pkg::CpOeUpper, u2a_pkg::CpUeUpper,
                                              u2a_pkg::CpSharpS};
  int unsigned                 cycle_cnt   = 0;
  int unsigned                 burst_left  = 0;
  int unsigned                 sent_bytes  = 0;

  utf8_to_ascii_transliterator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_o      (last_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: stall behavior steps through four patterns as the cycle count advances
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_char(out_char_o, last_o);
    case (cycle_cnt[8:7])
      2'd0: out_ready_i <= 1'b1;
      2'd1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2'd2: out_ready_i <= (cycle_cnt % 3 == 0);
      default: out_ready_i <= $urandom_range(0, 1);
    endcase
  end

  // encodes cp in nbytes bytes, overlong where cp is small
  function automatic void push_encoded(logic [u2a_pkg::AccW-1:0] cp, int nbytes);
    case (nbytes)
      2: stim_q.push_back({3'b110, cp[10:6]});
      3: stim_q.push_back({4'b1110, cp[15:12]});
      default: stim_q.push_back({5'b11110, cp[20:18]});
    endcase
    for (int i = nbytes - 2; i >= 0; i--) stim_q.push_back({2'b10, cp[6*i +: 6]});
  endfunction

  function automatic void push_token();
    int unsigned              kind;
    int                       n;
    logic [u2a_pkg::AccW-1:0] cp;
    kind = $urandom_range(0, 99);
    cp   = sub_cps[$urandom_range(0, 6)];
    n    = $urandom_range(2, 4);
    if (kind < 40) begin
      stim_q.push_back(8'($urandom_range(1, 127)));
    end else if (kind < 58) begin
      push_encoded(cp, 2);
    end else if (kind < 66) begin
      push_encoded(cp, n);
    end else if (kind < 76) begin
      push_encoded(21'($urandom), n);
    end else if (kind < 86) begin
      // truncated sequence: lead plus fewer continuations than it needs
      push_encoded(21'($urandom), n);
      repeat ($urandom_range(1, n - 1)) void'(stim_q.pop_back());
    end else if (kind < 93) begin
      if ($urandom_range(0, 1)) stim_q.push_back({2'b10, 6'($urandom)});
      else stim_q.push_back({5'b11111, 3'($urandom)});
    end else begin
      stim_q.push_back(8'($urandom_range(1, 255)));
    end
    if ($urandom_range(0, 11) == 0) stim_q.push_back(8'h00);
  endfunction

  task automatic write_max_len(logic [u2a_pkg::LenW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_max_len(v);
  endtask

  task automatic send_bytes();
    logic [u2a_pkg::ByteW-1:0] b;
    while (stim_q.size() != 0) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(1, 12);
      end
      b = stim_q.pop_front();
      in_valid_i <= 1'b1;
      in_byte_i  <= b;
      do @(posedge clk_i); while (!in_ready_o);
      void'(sb.note_byte(b));
      sent_bytes++;
      burst_left--;
    end
    in_valid_i <= 1'b0;
  endtask

  // drain, then let bytes that make no character clear the pipeline
  task automatic wait_idle();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    int unsigned              phase;
    logic [u2a_pkg::LenW-1:0] len;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_max_len(u2a_pkg::MaxLenReset);
    stim_q = '{8'h41, 8'h01, 8'h7F};
    foreach (sub_cps[i]) push_encoded(sub_cps[i], 2);
    push_encoded(u2a_pkg::CpAeLower, 3);
    push_encoded(u2a_pkg::CpUeUpper, 4);
    // broken sequence, stray bytes, terminator with a sequence open
    stim_q.push_back(8'hC3);
    stim_q.push_back(8'h41);
    stim_q.push_back(8'h80);
    stim_q.push_back(8'hF8);
    stim_q.push_back(8'hFF);
    stim_q.push_back(8'hC3);
    stim_q.push_back(8'h00);
    send_bytes();

    // cut pair with one slot, then ignored bytes
    wait_idle();
    write_max_len(16'd2);
    stim_q = '{8'hC3, 8'hA4, 8'h42, 8'h00};
    send_bytes();
    wait_idle();
    write_max_len(16'd1);
    stim_q = '{8'h41, 8'hC3, 8'hA4, 8'h00};
    send_bytes();
    wait_idle();
    write_max_len(16'd3);
    stim_q = '{8'h41, 8'hC3, 8'h9F, 8'h00};
    send_bytes();

    sent_bytes = 0;
    phase      = 0;
    while (sent_bytes < RandomBytes) begin
      wait_idle();
      case (phase)
        0: len = 16'hFFFF;
        1: len = 16'd1;
        default: begin
          case ($urandom_range(0, 9))
            0: len = 16'd1;
            1: len = 16'd2;
            2, 3: len = 16'($urandom_range(3, 12));
            4, 5: len = 16'($urandom_range(13, 64));
            6: len = u2a_pkg::MaxLenReset;
            7: len = 16'hFFFF;
            default: len = 16'($urandom_range(2, 30));
          endcase
        end
      endcase
      write_max_len(len);
      repeat ($urandom_range(10, 40)) push_token();
      if ($urandom_range(0, 1)) stim_q.push_back(8'h00);
      send_bytes();
      phase++;
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/u2a_pkg.sv
rtl/u2a_front.sv
rtl/u2a_fifo.sv
rtl/u2a_back.sv
rtl/utf8_to_ascii_transliterator.sv
rtl/u2a_checker.sv
tb/sv/utf8_to_ascii_transliterator_tb.sv
